@@ rtl/kmc_pkg.sv @@
// Shared constants, types and helper function of the k-mer histogram counter.
`timescale 1ns / 1ps

package kmc_pkg;

    function automatic int kmc_pow(input int base, input int expo);
        int acc;
        acc = 1;
        for (int i = 0; i < expo; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    localparam int KMER_LEN    = 6;
    localparam int COUNT_BITS  = 16;
    localparam int TABLE_DEPTH = 65536;

    localparam int CODE_BITS   = 3;
    localparam int INDEX_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int EPOCH_BITS  = 8;

    localparam int RADIX_P     = 6;
    localparam int RADIX_N     = 4;

    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CALC_BITS   = $clog2(kmc_pow(RADIX_P, KMER_LEN));
    localparam int ROLL_A      = (CALC_BITS > ADDR_BITS) ? CALC_BITS : ADDR_BITS;
    localparam int ROLL_BITS   = (ROLL_A > INDEX_W) ? ROLL_A : INDEX_W;
    localparam int FILL_BITS   = $clog2(KMER_LEN + 1);

    localparam int TOP_P       = kmc_pow(RADIX_P, KMER_LEN - 1);
    localparam int TOP_N       = kmc_pow(RADIX_N, KMER_LEN - 1);

    localparam logic MODE_PROTEIN    = 1'b0;
    localparam logic MODE_NUCLEOTIDE = 1'b1;

    typedef struct packed {
        logic                 kmer_valid;
        logic [ROLL_BITS-1:0] index;
        logic                 dropped;
        logic                 last;
    } t_req;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic               kmer_valid;
        logic [INDEX_W-1:0] kmer_index;
        logic [COUNT_W-1:0] kmer_count;
        logic               dropped;
        logic               end_of_sequence;
    } t_res;

endpackage

@@ rtl/kmc_if.sv @@
// Stream interfaces for the residue input channel and the k-mer result channel.
`timescale 1ns / 1ps

interface kmc_in_if import kmc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] group_code;
    logic                 last;

    modport source (output valid, output group_code, output last, input ready);
    modport sink   (input valid, input group_code, input last, output ready);
endinterface

interface kmc_out_if import kmc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kmer_valid;
    logic [INDEX_W-1:0] kmer_index;
    logic [COUNT_W-1:0] kmer_count;
    logic               dropped;
    logic               end_of_sequence;

    modport source (output valid, output kmer_valid, output kmer_index, output kmer_count,
                    output dropped, output end_of_sequence, input ready);
    modport sink   (input valid, input kmer_valid, input kmer_index, input kmer_count,
                    input dropped, input end_of_sequence, output ready);
endinterface

@@ rtl/kmer_histogram_counter.sv @@
// Top level of the k-mer histogram counter: window, count table and output register.
`timescale 1ns / 1ps

// Usage: residue group codes arrive on i_in, one per beat, with a last flag.
// Every input beat yields exactly one beat on o_out: the 6-mer index and its
// new saturating count when a full k-mer was formed, a dropped flag for codes
// outside the alphabet, and an echo of last. After a last beat the window and
// the per-sequence count table start empty again.
// i_cfg_we with i_cfg_wdata selects protein (0) or nucleotide (1) radix and
// clears the window; write it only while no beat is in flight.
// The result passes through the count stage and the output register on its way
// to o_out. One beat per cycle is sustained while o_out is ready and no sweep
// runs: the table read issued at acceptance returns in the next cycle, and the
// count write-back is forwarded to a following beat that reads the same entry.
// After reset, and after every 255th sequence, i_in.ready stays low during a
// sweep that retags all 65536 table entries. A stalled receiver holds the
// result in the output register; one further beat is accepted and parked in
// the count stage before i_in.ready falls.

module kmer_histogram_counter import kmc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    kmc_in_if.sink       i_in,
    kmc_out_if.source    o_out
);

    logic accept;
    logic req_ready;
    logic res_valid;
    logic out_slot_free;
    t_req req;
    t_res res;

    logic r_out_valid;
    t_res r_out;

    assign accept        = i_in.valid && req_ready;
    assign out_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready    = req_ready;

    kmc_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_group_code (i_in.group_code),
        .i_last       (i_in.last),
        .o_req        (req)
    );

    kmc_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (req),
        .i_out_ready (out_slot_free),
        .o_req_ready (req_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kmer_valid      = r_out.kmer_valid;
    assign o_out.kmer_index      = r_out.kmer_index;
    assign o_out.kmer_count      = r_out.kmer_count;
    assign o_out.dropped         = r_out.dropped;
    assign o_out.end_of_sequence = r_out.end_of_sequence;

endmodule

@@ rtl/kmc_window.sv @@
// Code window, rolling mixed-radix index, fill count and alphabet mode register.
`timescale 1ns / 1ps

module kmc_window import kmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [CODE_BITS-1:0] i_group_code,
    input  logic                 i_last,
    output t_req                 o_req
);

    logic                 r_mode;
    logic [CODE_BITS-1:0] r_win [KMER_LEN];
    logic [ROLL_BITS-1:0] r_roll;
    logic [FILL_BITS-1:0] r_fill;

    logic                 code_ok;
    logic [ROLL_BITS-1:0] trimmed;
    logic [ROLL_BITS-1:0] n_roll;
    logic [FILL_BITS-1:0] n_fill;

    always_comb begin
        if (r_mode == MODE_NUCLEOTIDE) begin
            code_ok = i_group_code < CODE_BITS'(RADIX_N);
            trimmed = r_roll - ROLL_BITS'(ROLL_BITS'(r_win[0]) * ROLL_BITS'(TOP_N));
            n_roll  = ROLL_BITS'(trimmed * ROLL_BITS'(RADIX_N)) + ROLL_BITS'(i_group_code);
        end else begin
            code_ok = i_group_code < CODE_BITS'(RADIX_P);
            trimmed = r_roll - ROLL_BITS'(ROLL_BITS'(r_win[0]) * ROLL_BITS'(TOP_P));
            n_roll  = ROLL_BITS'(trimmed * ROLL_BITS'(RADIX_P)) + ROLL_BITS'(i_group_code);
        end
        n_fill = (r_fill < FILL_BITS'(KMER_LEN)) ? r_fill + FILL_BITS'(1) : r_fill;

        o_req.kmer_valid = code_ok && (r_fill >= FILL_BITS'(KMER_LEN - 1));
        o_req.index      = o_req.kmer_valid ? n_roll : '0;
        o_req.dropped    = !code_ok;
        o_req.last       = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PROTEIN;
            r_roll <= '0;
            r_fill <= '0;
            for (int i = 0; i < KMER_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cfg_we || (i_accept && i_last)) begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_roll <= '0;
            r_fill <= '0;
            for (int i = 0; i < KMER_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_accept && code_ok) begin
            r_roll <= n_roll;
            r_fill <= n_fill;
            for (int i = 0; i < KMER_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[KMER_LEN-1] <= i_group_code;
        end
    end

endmodule

@@ rtl/kmc_table.sv @@
// Count table memory with epoch tags, read-modify-write stage, forwarding and clearing sweep.
`timescale 1ns / 1ps

module kmc_table import kmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    input  logic i_out_ready,
    output logic o_req_ready,
    output logic o_res_valid,
    output t_res o_res
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_entry                mem [TABLE_DEPTH];
    t_entry                r_rd;

    logic                  r_clearing;
    logic [ADDR_BITS-1:0]  r_clr_addr;
    logic [EPOCH_BITS-1:0] r_epoch;

    logic                  r1_valid;
    t_req                  r1_req;
    logic [EPOCH_BITS-1:0] r1_epoch;
    logic                  r1_fwd;
    t_entry                r1_fwd_data;

    logic                  s1_fire;
    logic                  sweep_we;
    logic                  wen;
    logic [ADDR_BITS-1:0]  waddr;
    t_entry                wdata;
    logic [ADDR_BITS-1:0]  raddr;
    t_entry                chosen;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] new_count;

    always_comb begin
        s1_fire     = r1_valid && i_out_ready;
        sweep_we    = r_clearing && !r1_valid;
        o_req_ready = !r_clearing && (!r1_valid || i_out_ready);
        raddr       = i_req.index[ADDR_BITS-1:0];

        chosen    = r1_fwd ? r1_fwd_data : r_rd;
        base      = (chosen.epoch == r1_epoch) ? chosen.count : '0;
        new_count = (base == COUNT_MAX) ? base : base + COUNT_BITS'(1);

        wen         = (s1_fire && r1_req.kmer_valid) || sweep_we;
        waddr       = sweep_we ? r_clr_addr : r1_req.index[ADDR_BITS-1:0];
        wdata.epoch = sweep_we ? '0 : r1_epoch;
        wdata.count = sweep_we ? '0 : new_count;

        o_res_valid            = r1_valid;
        o_res.kmer_valid       = r1_req.kmer_valid;
        o_res.kmer_index       = r1_req.index[INDEX_W-1:0];
        o_res.kmer_count       = r1_req.kmer_valid ? COUNT_W'(new_count) : '0;
        o_res.dropped          = r1_req.dropped;
        o_res.end_of_sequence  = r1_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd        <= mem[raddr];
            r1_req      <= i_req;
            r1_epoch    <= r_epoch;
            r1_fwd      <= wen && (waddr == raddr);
            r1_fwd_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_BITS'(1);
        end else begin
            r1_valid <= i_accept || (r1_valid && !i_out_ready);
            if (sweep_we) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_accept && i_req.last) begin
                if (r_epoch == '1) begin
                    r_epoch    <= EPOCH_BITS'(1);
                    r_clearing <= 1'b1;
                    r_clr_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + EPOCH_BITS'(1);
                end
            end
        end
    end

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !r_clearing)
        else $error("Beat accepted during the clearing sweep.");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("Live epoch equals the cleared tag.");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !i_out_ready) |=> (r1_valid && $stable(r1_req)))
        else $error("Stalled count stage lost its beat.");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && r1_req.kmer_valid) |-> (new_count != '0))
        else $error("Counted k-mer reports a zero count.");

endmodule
